// ----- sv/lcdq_pkg.sv -----
// ---------------------------------------------------------------------------
// lcdq_pkg
// Shared types and constants for the character-LCD command queue.
// ---------------------------------------------------------------------------
package lcdq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int ENTRY_W = KIND_W + BYTE_W;
  localparam int STAT_W  = 2;
  localparam int ACT_W   = 2;
  localparam int STEP_W  = 3;

  localparam logic [ACT_W-1:0] ACT_DATA  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSTR = 2'd1;

  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd2;

  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd0;
  localparam logic [STAT_W-1:0] ST_SENT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

  localparam logic [BYTE_W-1:0] PORT_E  = 8'h80;
  localparam logic [BYTE_W-1:0] PORT_RS = 8'h20;

  // sender beats: three per nibble, E high on the middle one
  localparam logic [STEP_W-1:0] STEP_HI_E   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HI_END = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LO_1ST = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LO_E   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LO_END = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ISSUE
  } ctrl_state_t;

  // request from the queue control to the sender
  typedef struct packed {
    logic              send;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [STAT_W-1:0] status;
  } send_req_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

// ----- sv/lcdq_ram.sv -----
// ---------------------------------------------------------------------------
// lcdq_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lcdq_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 10,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/lcdq_sender.sv -----
// ---------------------------------------------------------------------------
// lcdq_sender
// Turns one request into 4-bit port writes (value, value|E, value per nibble)
// or a single status beat, on the result stream.
// ---------------------------------------------------------------------------
module lcdq_sender
  import lcdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  send_req_t   req,
  output logic        req_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] port_value, [9:8] status, zero above
  output logic [0:0]  m_tuser,  // [0] write_valid
  output logic        m_tlast
);

  logic              active;
  logic [STEP_W-1:0] step;
  send_req_t         cur;

  logic              last_beat;
  logic              out_fire;
  logic [3:0]        nib;
  logic [BYTE_W-1:0] port;

  always_comb begin
    last_beat = !cur.send || step == STEP_LO_END ||
                (cur.kind == KIND_SINGLE && step == STEP_HI_END);
    out_fire  = m_tvalid && m_tready;
    req_ready = !active || (out_fire && last_beat);

    nib  = (step < STEP_LO_1ST) ? cur.value[7:4] : cur.value[3:0];
    port = {4'b0, nib};
    if (cur.kind == KIND_DATA) begin
      port = port | PORT_RS;
    end
    if (step == STEP_HI_E || step == STEP_LO_E) begin
      port = port | PORT_E;
    end
    if (!cur.send) begin
      port = '0;
    end

    m_tvalid = active;
    m_tdata  = {6'b0, cur.status, port};
    m_tuser  = cur.send;
    m_tlast  = last_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (req_valid && req_ready) begin
      active <= 1'b1;
      step   <= '0;
    end else if (out_fire) begin
      if (last_beat) begin
        active <= 1'b0;
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
  end

endmodule

// ----- sv/char_lcd_command_queue.sv -----
// ---------------------------------------------------------------------------
// char_lcd_command_queue
// Ring FIFO of LCD entries held in a RAM; each request enqueues or polls,
// then pops the oldest entry to the 4-bit port sender when the LCD is free.
// ---------------------------------------------------------------------------
// An accepted request goes straight to S_ISSUE when nothing is popped, or to
// S_READ (RAM read) and then S_ISSUE (hand-off to sender) when an entry is popped.
// A new request is taken once the previous one is handed to the sender; a popped
// entry then keeps the result stream busy for 6 beats (3 for upper-nibble-only).
// Reset (rst, synchronous): indices, FSM and sender cleared; RAM contents
// are undefined and never read before being written.
module char_lcd_command_queue
  import lcdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] byte_value, [8] single_nibble, [9] busy_flag
  input  logic [1:0]  s_tuser,  // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] port_value, [9:8] status, zero above
  output logic [0:0]  m_tuser,  // [0] write_valid
  output logic        m_tlast
);

  ctrl_state_t state, state_next;

  logic [IDX_W-1:0]  read_index;
  logic [IDX_W-1:0]  write_index;
  logic [IDX_W-1:0]  rd_addr;
  logic [STAT_W-1:0] pend_status;
  logic              pend_send;

  logic [BYTE_W-1:0]  in_byte;
  logic               in_single;
  logic               in_busy;
  logic               accept;
  logic               is_enq;
  logic               full;
  logic               overflow;
  logic               do_write;
  logic               empty_after;
  logic               do_pop;
  logic [IDX_W-1:0]   wr_next;
  logic [IDX_W-1:0]   w_after;
  logic [KIND_W-1:0]  in_kind;
  logic [STAT_W-1:0]  status_now;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  logic               req_valid;
  logic               req_ready;
  send_req_t          req;

  always_comb begin
    in_byte   = s_tdata[7:0];
    in_single = s_tdata[8];
    in_busy   = s_tdata[9];
    accept    = s_tvalid && s_tready;

    is_enq   = s_tuser == ACT_DATA || s_tuser == ACT_INSTR;
    wr_next  = next_idx(write_index);
    full     = wr_next == read_index;
    overflow = is_enq && full;
    do_write = accept && is_enq && !full;
    w_after  = (is_enq && !full) ? wr_next : write_index;

    if (s_tuser == ACT_DATA) begin
      in_kind = KIND_DATA;
    end else if (in_single) begin
      in_kind = KIND_SINGLE;
    end else begin
      in_kind = KIND_FULL;
    end

    empty_after = w_after == read_index;
    do_pop      = !empty_after && !in_busy;

    if (overflow) begin
      status_now = ST_OVF;
    end else if (empty_after) begin
      status_now = ST_EMPTY;
    end else if (in_busy) begin
      status_now = ST_BUSY;
    end else begin
      status_now = ST_SENT;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    req_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = do_pop ? S_READ : S_ISSUE;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        req_valid = 1'b1;
        if (req_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    req.send   = pend_send;
    req.kind   = rd_data[ENTRY_W-1:BYTE_W];
    req.value  = rd_data[BYTE_W-1:0];
    req.status = pend_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      read_index  <= '0;
      write_index <= '0;
    end else begin
      state <= state_next;
      if (do_write) begin
        write_index <= wr_next;
      end
      if (accept && do_pop) begin
        read_index <= next_idx(read_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr     <= read_index;
      pend_status <= status_now;
      pend_send   <= do_pop;
    end
  end

  lcdq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (write_index),
    .wr_data ({in_kind, in_byte}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lcdq_sender u_sender (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  a_nowrite_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'h00)
    else $error("status-only result must be a single zero beat");

  a_e_needs_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |-> m_tuser[0])
    else $error("E strobe on a non-write result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous still in control");

  a_read_then_issue: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_ISSUE && pend_send)
    else $error("RAM read not followed by a send request");
`endif

endmodule

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character-LCD command queue: random and
// directed requests on the input stream, a software queue predictor, and an
// in-order check of every result beat on the output stream.
// ---------------------------------------------------------------------------
module tb_top
  import lcdq_pkg::*;
();

  localparam logic [ACT_W-1:0] ACT_POLL  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct {
    logic              write_valid;
    logic [BYTE_W-1:0] port_value;
    logic [STAT_W-1:0] status;
    logic              last;
  } lcd_beat_t;

  // Queue predictor plus the list of port beats still owed by the block.
  class lcd_scoreboard;
    logic [ENTRY_W-1:0] store [QUEUE_DEPTH];
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;
    lcd_beat_t          owed [$];
    int errors, n_requests, n_writes, n_busy, n_empty, n_ovf;

    function new();
      rd_idx = '0;
      wr_idx = '0;
      errors = 0;
      n_requests = 0;
      n_writes = 0;
      n_busy = 0;
      n_empty = 0;
      n_ovf = 0;
    endfunction

    function logic [IDX_W-1:0] bump(logic [IDX_W-1:0] i);
      return (int'(i) == QUEUE_DEPTH - 1) ? '0 : i + 1'b1;
    endfunction

    function void owe(logic wv, logic [BYTE_W-1:0] pv, logic [STAT_W-1:0] st, logic lst);
      lcd_beat_t b;
      b.write_valid = wv;
      b.port_value  = pv;
      b.status      = st;
      b.last        = lst;
      owed.push_back(b);
    endfunction

    // value, value|E, value
    function void owe_nibble(logic [BYTE_W-1:0] v, logic [STAT_W-1:0] st, logic fin);
      owe(1'b1, v, st, 1'b0);
      owe(1'b1, v | PORT_E, st, 1'b0);
      owe(1'b1, v, st, fin);
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
                               logic single, logic busy);
      logic               ovf;
      logic [KIND_W-1:0]  kind;
      logic [IDX_W-1:0]   nw;
      logic [ENTRY_W-1:0] e;
      logic [BYTE_W-1:0]  rs;
      logic [STAT_W-1:0]  st;
      ovf = 1'b0;
      n_requests++;
      if (act == ACT_DATA || act == ACT_INSTR) begin
        kind = (act == ACT_DATA) ? KIND_DATA : (single ? KIND_SINGLE : KIND_FULL);
        nw = bump(wr_idx);
        if (nw == rd_idx) begin
          ovf = 1'b1;
        end else begin
          store[wr_idx] = {kind, b};
          wr_idx = nw;
        end
      end
      if (ovf) n_ovf++;
      if (rd_idx == wr_idx) begin
        n_empty++;
        owe(1'b0, '0, ovf ? ST_OVF : ST_EMPTY, 1'b1);
      end else if (busy) begin
        n_busy++;
        owe(1'b0, '0, ovf ? ST_OVF : ST_BUSY, 1'b1);
      end else begin
        e = store[rd_idx];
        rd_idx = bump(rd_idx);
        st = ovf ? ST_OVF : ST_SENT;
        rs = (e[ENTRY_W-1:BYTE_W] == KIND_DATA) ? PORT_RS : '0;
        owe_nibble({4'h0, e[7:4]} | rs, st, e[ENTRY_W-1:BYTE_W] == KIND_SINGLE);
        if (e[ENTRY_W-1:BYTE_W] != KIND_SINGLE)
          owe_nibble({4'h0, e[3:0]} | rs, st, 1'b1);
      end
    endfunction

    function void check_result(logic wv, logic [BYTE_W-1:0] pv, logic [STAT_W-1:0] st,
                               logic lst, logic [5:0] pad);
      lcd_beat_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: port_value %0h status %0d", pv, st);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (wv) n_writes++;
      if (wv !== want.write_valid) begin
        $error("write_valid: expected %0b, got %0b", want.write_valid, wv);
        errors++;
      end
      if (pv !== want.port_value) begin
        $error("port_value: expected %0h, got %0h", want.port_value, pv);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        errors++;
      end
      if (pad !== 6'd0) begin
        $error("tdata padding: expected 0, got %0h", pad);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  lcd_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_left;
  bit hold_req;
  int cycle_count;

  char_lcd_command_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("char_lcd_command_queue regression: fail");
      $finish;
    end
  end

  // results are checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tuser[0], m_tdata[7:0], m_tdata[9:8], m_tlast, m_tdata[15:10]);
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]);
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
                           logic single, logic busy);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, busy, single, b};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_wait();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(ACT_POLL,  8'h00, 1'b0, 1'b0);  // empty queue
    send_item(ACT_SPARE, 8'hff, 1'b1, 1'b1);  // unused code polls
    send_item(ACT_DATA,  8'h00, 1'b0, 1'b0);
    send_item(ACT_DATA,  8'hff, 1'b1, 1'b0);  // single flag ignored on data
    send_item(ACT_INSTR, 8'hff, 1'b0, 1'b0);
    send_item(ACT_INSTR, 8'ha5, 1'b1, 1'b0);  // upper nibble only
    send_item(ACT_INSTR, 8'h00, 1'b0, 1'b1);
    send_item(ACT_DATA,  8'h5a, 1'b0, 1'b1);
    send_item(ACT_POLL,  8'h3c, 1'b0, 1'b1);
    send_item(ACT_POLL,  8'hc3, 1'b1, 1'b0);
    send_item(ACT_SPARE, 8'h00, 1'b0, 1'b0);
    send_item(ACT_INSTR, 8'hff, 1'b1, 1'b0);
    send_item(ACT_INSTR, 8'h0f, 1'b1, 1'b0);
    send_item(ACT_DATA,  8'h80, 1'b0, 1'b0);
    send_item(ACT_DATA,  8'h01, 1'b1, 1'b0);
    send_item(ACT_POLL,  8'hff, 1'b1, 1'b0);
  endtask

  // fill to capacity with the LCD busy, overflow, then drain by polling
  task automatic fill_and_drain();
    repeat (QUEUE_DEPTH - 1)
      send_item($urandom_range(1) ? ACT_INSTR : ACT_DATA, BYTE_W'($urandom),
                1'($urandom), 1'b1);
    repeat (3)
      send_item(ACT_DATA, BYTE_W'($urandom), 1'($urandom), 1'b1);
    send_item(ACT_INSTR, BYTE_W'($urandom), 1'b0, 1'b0);  // dropped, pop still runs
    repeat (QUEUE_DEPTH + 2)
      send_item($urandom_range(1) ? ACT_SPARE : ACT_POLL, BYTE_W'($urandom),
                1'($urandom), $urandom_range(9) == 0);
  endtask

  task automatic random_items(int n);
    int busy_pct;
    int r;
    logic [ACT_W-1:0] act;
    busy_pct = 50;
    for (int i = 0; i < n; i++) begin
      // busy bias drifts so the queue grows and shrinks
      if (i % 20 == 0) busy_pct = $urandom_range(85, 5);
      r = $urandom_range(99);
      if (r < 40)      act = ACT_DATA;
      else if (r < 75) act = ACT_INSTR;
      else if (r < 95) act = ACT_POLL;
      else             act = ACT_SPARE;
      send_item(act, BYTE_W'($urandom), 1'($urandom), $urandom_range(99) < busy_pct);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    hold_left = 0;
    hold_req = 1'b0;
    cycle_count = 0;
    send_idle = 38;
    recv_idle = 78;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_items();
    drain_wait();
    fill_and_drain();
    random_items(41);
    drain_wait();

    send_idle = 78;
    recv_idle = 38;
    random_items(41);
    drain_wait();

    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    random_items(41);
    drain_wait();

    $display("covered %0d requests, %0d port write beats checked", sb.n_requests,
             sb.n_writes);
    $display("no-send outcomes: %0d empty, %0d busy; %0d enqueues dropped on a full queue",
             sb.n_empty, sb.n_busy, sb.n_ovf);
    if (sb.errors == 0) begin
      $display("char_lcd_command_queue regression: pass");
    end else begin
      $display("char_lcd_command_queue regression: fail");
    end
    $finish;
  end

endmodule
